// ===== hw/rtl/gn3_pkg.sv =====
// shared types, constants and functions for the 3d gradient noise unit
`timescale 1ns / 1ps
package gn3_pkg;
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KZ = 32'd1274126177;
  localparam logic [31:0] HASH_KM = 32'd1103515245;
  localparam int unsigned HASH_SH1 = 13;
  localparam int unsigned HASH_SH2 = 16;
  localparam logic [31:0] SEED_RESET = 32'd12345;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned OUT_W = 18;
  localparam int unsigned CORNERS = 8;
  localparam logic [0:0] CFG_ADDR_SEED = 1'd0;

  typedef logic [3:0] grad_idx_t;
  typedef logic signed [1:0] grad_comp_t;

  typedef struct packed {
    grad_comp_t gx;
    grad_comp_t gy;
    grad_comp_t gz;
  } grad_t;

  function automatic grad_t grad_lookup(input grad_idx_t idx);
    grad_t g;
    case (idx)
      4'd0:    g = '{2'sd1, 2'sd1, 2'sd0};
      4'd1:    g = '{-2'sd1, 2'sd1, 2'sd0};
      4'd2:    g = '{2'sd1, -2'sd1, 2'sd0};
      4'd3:    g = '{-2'sd1, -2'sd1, 2'sd0};
      4'd4:    g = '{2'sd1, 2'sd0, 2'sd1};
      4'd5:    g = '{-2'sd1, 2'sd0, 2'sd1};
      4'd6:    g = '{2'sd1, 2'sd0, -2'sd1};
      4'd7:    g = '{-2'sd1, 2'sd0, -2'sd1};
      4'd8:    g = '{2'sd0, 2'sd1, 2'sd1};
      4'd9:    g = '{2'sd0, -2'sd1, 2'sd1};
      4'd10:   g = '{2'sd0, 2'sd1, -2'sd1};
      4'd11:   g = '{2'sd0, -2'sd1, -2'sd1};
      default: g = '{2'sd0, 2'sd0, 2'sd0};
    endcase
    return g;
  endfunction
endpackage

// ===== hw/rtl/gradient_noise_3d_unit.sv =====
// top level of the 3d gradient noise unit
// channel | dir | fields
// in_     | in  | tdata: coord_x, coord_y, coord_z (96 bits)
// out_    | out | tdata: noise_value (18 bits, 24 wide)
// cfg_    | in  | apb register seed at 0x0
// one point per cycle sustained while out_tready does not stall; points pass through hash and blend stages
// throughput set by the fully pipelined hash multipliers and blend multipliers
// a stall on out_tready holds every stage and drops in_tready
// reset clears valid bits and seed to 12345
`timescale 1ns / 1ps
module gradient_noise_3d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coord_x, coord_y, coord_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // noise_value
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int FW = FRAC_BITS;
  localparam int VW = FW + 6;
  localparam int PW = 2 * VW;
  localparam int NS = 11;
  localparam int ND = 4;
  localparam logic signed [VW-1:0] ONE = VW'(1) << FW;

  logic [31:0] seed_r;
  logic        adv;
  logic [NS-1:0] vld_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:2] == gn3_pkg::CFG_ADDR_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= gn3_pkg::SEED_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2:2] == gn3_pkg::CFG_ADDR_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[NS-1];

  // stage 0: floor and fraction
  logic signed [31:0] px, py, pz;
  logic [31:0] x0, y0, z0;
  logic signed [VW-1:0] fx0, fy0, fz0;
  assign px = in_tdata[31:0];
  assign py = in_tdata[63:32];
  assign pz = in_tdata[95:64];
  assign x0 = 32'(px >>> FW);
  assign y0 = 32'(py >>> FW);
  assign z0 = 32'(pz >>> FW);
  assign fx0 = VW'({1'b0, px[FW-1:0]});
  assign fy0 = VW'({1'b0, py[FW-1:0]});
  assign fz0 = VW'({1'b0, pz[FW-1:0]});

  // fraction delay line
  logic signed [VW-1:0] fx_d [ND];
  logic signed [VW-1:0] fy_d [ND];
  logic signed [VW-1:0] fz_d [ND];
  always_ff @(posedge clk) begin
    if (adv) begin
      fx_d[0] <= fx0;
      fy_d[0] <= fy0;
      fz_d[0] <= fz0;
      for (int i = 1; i < ND; i++) begin
        fx_d[i] <= fx_d[i-1];
        fy_d[i] <= fy_d[i-1];
        fz_d[i] <= fz_d[i-1];
      end
    end
  end

  // hashes, 4 stages: index valid with fractions at fx_d[3]
  gn3_pkg::grad_idx_t gi [gn3_pkg::CORNERS];
  for (genvar c = 0; c < gn3_pkg::CORNERS; c++) begin : g_hash
    gn3_hash u_hash (
      .clk  (clk),
      .en   (adv),
      .cx   (x0 + 32'(c & 1)),
      .cy   (y0 + 32'((c >> 1) & 1)),
      .cz   (z0 + 32'((c >> 2) & 1)),
      .seed (seed_r),
      .idx  (gi[c])
    );
  end

  // smootherstep, stages 0..3 in parallel
  function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return VW'(p >>> FW);
  endfunction
  logic signed [VW-1:0] sb_r [3];
  logic signed [VW-1:0] st2_r [3];
  logic signed [VW-1:0] st3_r [3];
  logic signed [VW-1:0] sbb_r [3];
  logic signed [VW-1:0] sw_r [3];
  logic signed [VW-1:0] tin [3];
  logic signed [VW-1:0] t1 [3];
  logic signed [VW-1:0] t2 [3];
  logic signed [VW-1:0] sbb2_r [3];
  assign tin[0] = fx0;
  assign tin[1] = fy0;
  assign tin[2] = fz0;
  assign t1[0] = fx_d[0];
  assign t1[1] = fy_d[0];
  assign t1[2] = fz_d[0];
  assign t2[0] = fx_d[1];
  assign t2[1] = fy_d[1];
  assign t2[2] = fz_d[1];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sb_r[k]  <= VW'(6) * tin[k] - VW'(15) * ONE;
        st2_r[k] <= mulq(t1[k], t1[k]);
        sbb_r[k] <= mulq(t1[k], sb_r[k]) + VW'(10) * ONE;
        st3_r[k] <= mulq(st2_r[k], t2[k]);
        sw_r[k]  <= mulq(st3_r[k], sbb2_r[k]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) sbb2_r[k] <= sbb_r[k];
    end
  end

  // stage: dot products (aligned with fx_d[3])
  logic signed [VW-1:0] d_r [gn3_pkg::CORNERS];
  logic signed [VW-1:0] u_r, v1_r, w1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < gn3_pkg::CORNERS; c++) begin
        gn3_pkg::grad_t g;
        logic signed [VW-1:0] ox, oy, oz, sx, sy, sz;
        g  = gn3_pkg::grad_lookup(gi[c]);
        ox = ((c & 1) != 0) ? fx_d[3] - ONE : fx_d[3];
        oy = ((c & 2) != 0) ? fy_d[3] - ONE : fy_d[3];
        oz = ((c & 4) != 0) ? fz_d[3] - ONE : fz_d[3];
        sx = (g.gx == 2'sd0) ? '0 : ((g.gx == 2'sd1) ? ox : -ox);
        sy = (g.gy == 2'sd0) ? '0 : ((g.gy == 2'sd1) ? oy : -oy);
        sz = (g.gz == 2'sd0) ? '0 : ((g.gz == 2'sd1) ? oz : -oz);
        d_r[c] <= sx + sy + sz;
      end
      u_r  <= sw_r[0];
      v1_r <= sw_r[1];
      w1_r <= sw_r[2];
    end
  end

  // blend stages: x (ex_m_r then e_r), y (fm_r then f_r), z (rm_r with ra_r)
  function automatic logic signed [VW-1:0] lmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] w);
    logic signed [PW-1:0] p;
    p = PW'(b - a) * PW'(w);
    return VW'(p >>> FW);
  endfunction
  logic signed [VW-1:0] ex_m_r [4], ex_a_r [4], e_r [4];
  logic signed [VW-1:0] v2_r, v3_r, w2_r, w3_r, w4_r, w5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        ex_m_r[k] <= lmul(d_r[2*k], d_r[2*k+1], u_r);
        ex_a_r[k] <= d_r[2*k];
        e_r[k]    <= ex_a_r[k] + ex_m_r[k];
      end
      v2_r <= v1_r; v3_r <= v2_r;
      w2_r <= w1_r; w3_r <= w2_r; w4_r <= w3_r; w5_r <= w4_r;
    end
  end
  logic signed [VW-1:0] fm_r [2], fa_r [2], f_r [2];
  logic signed [VW-1:0] rm_r, ra_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        fm_r[k] <= lmul(e_r[2*k], e_r[2*k+1], v3_r);
        fa_r[k] <= e_r[2*k];
        f_r[k]  <= fa_r[k] + fm_r[k];
      end
      rm_r <= lmul(f_r[0], f_r[1], w5_r);
      ra_r <= f_r[0];
    end
  end

  // final: sum, rescale, saturate into output register
  logic signed [VW+16:0] rs, rsc;
  logic signed [gn3_pkg::OUT_W-1:0] nv;
  always_comb begin
    rs = (VW+17)'(ra_r) + (VW+17)'(rm_r);
    if (FW >= 16) rsc = rs >>> (FW - 16);
    else          rsc = rs <<< (16 - FW);
    if (rsc > (VW+17)'(131071))       nv = 18'sd131071;
    else if (rsc < -(VW+17)'(131072)) nv = -18'sd131072;
    else                              nv = gn3_pkg::OUT_W'(rsc);
  end
  logic [gn3_pkg::OUT_W-1:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) out_r <= nv;
  end
  assign out_tdata = {6'd0, out_r};
endmodule

// ===== hw/rtl/gn3_hash.sv =====
// pipelined seeded corner hash, 32-bit value reduced modulo 12 into a gradient index
`timescale 1ns / 1ps
module gn3_hash (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          cx,
  input  logic [31:0]          cy,
  input  logic [31:0]          cz,
  input  logic [31:0]          seed,
  output gn3_pkg::grad_idx_t   idx
);
  logic [31:0] px_r, py_r, pz_r;
  logic [31:0] h_r;
  logic [31:0] m_r;
  gn3_pkg::grad_idx_t idx_r;
  logic [31:0] hs, ms;

  // modulo 12: low two bits kept, upper part modulo 3 by digit folding
  function automatic gn3_pkg::grad_idx_t mod12(input logic [31:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 1; i < 16; i++) s1 = s1 + 6'(v[2*i +: 2]);
    s2 = 4'(s1[5:4]) + 4'(s1[3:2]) + 4'(s1[1:0]);
    s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
    if (s3 >= 3'd3) s3 = s3 - 3'd3;
    return {s3[1:0], v[1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= (cx + seed) * gn3_pkg::HASH_KX;
      py_r <= (cy + seed * 32'd3) * gn3_pkg::HASH_KY;
      pz_r <= (cz + seed * 32'd7) * gn3_pkg::HASH_KZ;
    end
  end

  assign hs = px_r + py_r + pz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= hs ^ 32'($signed(hs) >>> gn3_pkg::HASH_SH1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= h_r * gn3_pkg::HASH_KM;
    end
  end

  assign ms = m_r ^ 32'($signed(m_r) >>> gn3_pkg::HASH_SH2);

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= mod12(ms);
    end
  end

  assign idx = idx_r;
endmodule

// ===== hw/rtl/gn3_checker.sv =====
// port-level checker for the 3d gradient noise unit, bound to the top level
`timescale 1ns / 1ps
module gn3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_pready
);
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:18] == 6'd0) else $error("pad bits set");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready) else $error("input blocked");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("beat changed");
  a_prdy: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind gradient_noise_3d_unit gn3_checker u_gn3_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .cfg_pready(cfg_pready)
);
